// File: rtl/sat_pkg.sv
// Shared types and constants for the splash age table.
// No dependencies; every other file in this block but sat_ram depends on it.
package sat_pkg;

    localparam int MODE_W            = 2;
    localparam int STEP_W            = 16;
    localparam int ID_W              = 16;
    localparam int AGE_W             = 22;
    localparam int TABLE_ENTRIES_DEF = 32;

    // 9999 s with 8 fraction bits.
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(2559744);

    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CREATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input word and clear the scan
        logic issue;   // read the next record and advance the scan index
        logic commit;  // apply a create and load the result word
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every stored record has been read
        logic rd_busy;    // read data is still arriving from the table
        logic out_free;   // the result register can take a new word
    } t_ctl_sts;

endpackage

// File: rtl/sat_if.sv
// Valid/ready channel interfaces for the splash age table.
// Depends on sat_pkg for the field widths.
interface sat_in_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::MODE_W-1:0]   mode;
    logic [sat_pkg::STEP_W-1:0]   step_time;
    logic [sat_pkg::ID_W-1:0]     owner_id;
    logic                         can_ripple;

    modport source (output valid, mode, step_time, owner_id, can_ripple, input ready);
    modport sink   (input valid, mode, step_time, owner_id, can_ripple, output ready);
endinterface

interface sat_out_if;
    logic                         valid;
    logic                         ready;
    logic [sat_pkg::AGE_W-1:0]    newest_age;
    logic                         recorded;

    modport source (output valid, newest_age, recorded, input ready);
    modport sink   (input valid, newest_age, recorded, output ready);
endinterface

// File: rtl/sat_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sat_ctrl.sv
// Controller state machine for the splash age table.
// Depends on sat_pkg for the command and status structs.
module sat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sat_pkg::t_ctl_sts i_sts,
    output sat_pkg::t_ctl_cmd o_cmd
);
    import sat_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_ctl_cmd n_cmd;

    always_comb begin
        n_state = r_state;
        n_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.scan_done) begin
                    n_cmd.issue = 1'b1;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_sts.rd_busy && i_sts.out_free) begin
                    n_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // No word is taken while reset is held.
    assign o_in_ready = (r_state == ST_IDLE) && i_rst_n;
    assign o_cmd      = n_cmd;

endmodule

// File: rtl/sat_dpath.sv
// Datapath of the splash age table: record RAM, scan index, accumulators, result register.
// Depends on sat_pkg and sat_ram.
module sat_dpath #(
    parameter int TABLE_ENTRIES = sat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sat_pkg::t_ctl_cmd          i_cmd,
    output sat_pkg::t_ctl_sts          o_sts,
    input  logic [sat_pkg::MODE_W-1:0] i_mode,
    input  logic [sat_pkg::STEP_W-1:0] i_step_time,
    input  logic [sat_pkg::ID_W-1:0]   i_owner_id,
    input  logic                       i_can_ripple,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [sat_pkg::AGE_W-1:0]  o_newest_age,
    output logic                       o_recorded
);
    import sat_pkg::*;

    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int WORD_W = ID_W + AGE_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

    // Captured input word.
    logic [MODE_W-1:0] r_mode;
    logic [STEP_W-1:0] r_step;
    logic [ID_W-1:0]   r_owner;
    logic              r_ripple;

    // Scan state.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_rd_idx;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_idx_d;
    logic [AGE_W-1:0]  r_best_age;
    logic [IDX_W-1:0]  r_best_idx;
    logic [AGE_W-1:0]  r_min_age;

    // Result register.
    logic              r_out_vld;
    logic [AGE_W-1:0]  r_out_age;
    logic              r_out_rec;

    logic [WORD_W-1:0] rd_word;
    logic [AGE_W-1:0]  rd_age;
    logic [ID_W-1:0]   rd_owner;
    logic [AGE_W:0]    age_sum;
    logic [AGE_W-1:0]  age_sat;
    logic              tick_we;
    logic              can_append;
    logic              create_we;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;

    sat_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (rd_word)
    );

    assign rd_owner = rd_word[WORD_W-1:AGE_W];
    assign rd_age   = rd_word[AGE_W-1:0];
    assign age_sum  = {1'b0, rd_age} + (AGE_W + 1)'(r_step);
    assign age_sat  = (age_sum > {1'b0, AGE_MAX}) ? AGE_MAX : age_sum[AGE_W-1:0];

    assign tick_we    = r_rd_vld && (r_mode == MODE_TICK);
    assign can_append = (r_count < CNT_FULL);
    assign create_we  = i_cmd.commit && (r_mode == MODE_CREATE) && r_ripple
                        && ((r_best_age != '0) || can_append);
    assign ram_we     = tick_we || create_we;

    always_comb begin
        if (tick_we) begin
            ram_waddr = r_rd_idx_d;
            ram_wdata = {rd_owner, age_sat};
        end else begin
            ram_waddr = (r_best_age != '0) ? r_best_idx : r_count[IDX_W-1:0];
            ram_wdata = {r_owner, AGE_W'(0)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (create_we && (r_best_age == '0)) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx_d <= r_rd_idx[IDX_W-1:0];
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_step     <= i_step_time;
            r_owner    <= i_owner_id;
            r_ripple   <= i_can_ripple;
            r_rd_idx   <= '0;
            r_best_age <= '0;
            r_best_idx <= '0;
            r_min_age  <= AGE_MAX;
        end else begin
            if (i_cmd.issue) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
            end
            if (r_rd_vld) begin
                // The first record with the strictly largest age wins.
                if (rd_age > r_best_age) begin
                    r_best_age <= rd_age;
                    r_best_idx <= r_rd_idx_d;
                end
                if ((rd_owner == r_owner) && (rd_age < r_min_age)) begin
                    r_min_age <= rd_age;
                end
            end
        end
        if (i_cmd.commit) begin
            r_out_age <= (r_mode == MODE_QUERY) ? r_min_age : '0;
            r_out_rec <= create_we;
        end
    end

    assign o_sts.scan_done = (r_rd_idx == r_count);
    assign o_sts.rd_busy   = r_rd_vld;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign o_out_valid  = r_out_vld;
    assign o_newest_age = r_out_age;
    assign o_recorded   = r_out_rec;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("record count exceeds the table size");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ({1'b0, r_rd_idx_d} < (IDX_W + 1)'(r_count)))
        else $error("scan read a record beyond the stored count");

    a_recorded_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_rec) |-> (r_count != '0))
        else $error("create reported as recorded with an empty table");

    a_age_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_age <= AGE_MAX))
        else $error("result age above the saturation limit");

    a_commit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_rd_vld)
        else $error("commit while table read data is still in flight");

endmodule

// File: rtl/splash_age_table_core.sv
// Top level of the splash age table: controller, datapath and the channel ports.
// Depends on sat_pkg, sat_if, sat_ctrl and sat_dpath.
//
// The block keeps up to TABLE_ENTRIES records of (owner id, age), ages unsigned with
// 8 fraction bits and saturating at 9999 s. Every input word gives exactly one result
// word. A tick adds step_time to every stored age. A create with can_ripple set
// overwrites the first record holding the largest nonzero age with age 0 and the new
// owner, appends a record when every age is zero, and drops the splash when the table
// is then full; recorded tells whether a record was stored. A query returns the
// smallest age among records of owner_id, or 9999 s (2559744) when there is none.
// Fields that do not belong to the word's mode read as zero; mode 3 changes nothing.
// Each word walks the stored records once through the single read port of the record
// RAM, one record per cycle: the word is loaded, every stored record is read, the end
// of the walk is seen, and the word commits once the output register is free; its
// result word is then offered from that register.
// Tick write-backs share the cycles of that walk through the separate write port.
// One word is processed at a time. The result sits in an output register, so a new
// word is taken while the previous result waits; the block only holds its final
// update until that register frees up. After reset the table is empty and needs no
// clearing pass.
module splash_age_table_core #(
    parameter int TABLE_ENTRIES = sat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sat_in_if.sink     i_in,
    sat_out_if.source  o_out
);
    import sat_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Sequencing of the load, scan and commit phases of one word.
    sat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Record storage, scan accumulators and the result register.
    sat_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (i_in.mode),
        .i_step_time  (i_in.step_time),
        .i_owner_id   (i_in.owner_id),
        .i_can_ripple (i_in.can_ripple),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_newest_age (o_out.newest_age),
        .o_recorded   (o_out.recorded)
    );

endmodule

// File: tb/sv/splash_age_table_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for splash_age_table_core: directed table, then random phases.
// Depends on sat_pkg, sat_if (sat_in_if, sat_out_if) and the splash_age_table_core RTL.
module splash_age_table_core_tb;
    import sat_pkg::*;

    localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;

    // Mode 3 is not decoded by the block; it must change nothing and return zeros.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // About 1100 random words after the directed table; the last stretch runs with no
    // idling on either side so back-to-back words are exercised at full rate.
    localparam int TOTAL_WORDS = 1124;
    localparam int CALM_WORDS  = 150;

    // The limit lies far above the longest a word can take inside the block together with
    // a sender gap and a receiver stall.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = TABLE_ENTRIES + 8;
    localparam int MAX_PRINTED    = 40;

    typedef enum {
        PH_MIX,       // all modes, full-range and small steps
        PH_FILL,      // long runs of creates: fills the table, then drops on a full table
        PH_SATURATE,  // large steps until every age pins at 9999 s
        PH_CREEP,     // tiny steps, so ages tie often
        PH_PROBE      // queries only
    } t_phase;

    typedef struct packed {
        logic [AGE_W-1:0] age;
        logic             recorded;
    } t_age_word;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] step;
        logic [ID_W-1:0]   owner;
        logic              ripple;
        logic              typed;     // expected result is written in the row itself
        logic [AGE_W-1:0]  age;
        logic              recorded;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    sat_in_if  in_ch ();
    sat_out_if out_ch ();

    splash_age_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the record table, updated once per accepted input word.
    int unsigned      rec_count;
    logic [AGE_W-1:0] rec_age   [TABLE_ENTRIES];
    logic [ID_W-1:0]  rec_owner [TABLE_ENTRIES];

    // Results still owed by the block, oldest first.
    t_age_word owed_results [$];

    // Sideband that travels with the payload of the word being offered.
    logic             word_typed;
    logic [AGE_W-1:0] word_exp_age;
    logic             word_exp_rec;

    bit src_idle_on;
    bit sink_stall_on;
    int sink_hold_left;
    int quiet_cycles;

    int mismatch_count;
    int words_sent;
    int results_checked;
    int n_tick, n_create, n_query, n_unused;
    int n_stored, n_dropped, n_saturated;

    logic [ID_W-1:0] owner_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                        16'h1234, 16'h00FF, 16'hFF00, 16'h5555};

    t_dir_row dir_rows [$];

    // Clock: 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one word to the shadow table and return the result the block must give.
    function automatic t_age_word splash_table_step(logic [MODE_W-1:0] mode,
                                                    logic [STEP_W-1:0] step,
                                                    logic [ID_W-1:0] owner,
                                                    logic ripple);
        t_age_word        res;
        logic [AGE_W:0]   sum;
        logic [AGE_W-1:0] best_age;
        int unsigned      best_idx;
        bit               found;
        res      = '0;
        best_age = '0;
        best_idx = 0;
        found    = 1'b0;
        case (mode)
            MODE_TICK: begin
                for (int i = 0; i < rec_count; i++) begin
                    sum = {1'b0, rec_age[i]} + (AGE_W + 1)'(step);
                    if (sum > (AGE_W + 1)'(AGE_MAX)) begin
                        rec_age[i] = AGE_MAX;
                        n_saturated++;
                    end else begin
                        rec_age[i] = sum[AGE_W-1:0];
                    end
                end
            end
            MODE_CREATE: begin
                if (ripple) begin
                    // Strict compare keeps the lowest index among equal largest ages.
                    for (int i = 0; i < rec_count; i++) begin
                        if (rec_age[i] > best_age) begin
                            best_age = rec_age[i];
                            best_idx = i;
                            found    = 1'b1;
                        end
                    end
                    if (found) begin
                        rec_age[best_idx]   = '0;
                        rec_owner[best_idx] = owner;
                        res.recorded        = 1'b1;
                    end else if (rec_count < TABLE_ENTRIES) begin
                        rec_age[rec_count]   = '0;
                        rec_owner[rec_count] = owner;
                        rec_count++;
                        res.recorded = 1'b1;
                    end else begin
                        n_dropped++;
                    end
                    if (res.recorded) n_stored++;
                end
            end
            MODE_QUERY: begin
                res.age = AGE_MAX;
                for (int i = 0; i < rec_count; i++) begin
                    if (rec_owner[i] == owner && rec_age[i] < res.age) res.age = rec_age[i];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("%0t: result %0d %s: expected %0d, got %0d",
                     $time, results_checked, what, want_v, got_v);
        end
    endtask

    // Both channels are sampled at the rising edge, before any update of that edge lands.
    // The output is checked first; its word always belongs to an earlier input word.
    always @(posedge i_clk) begin
        t_age_word got;
        t_age_word want;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                results_checked++;
                got.age      = out_ch.newest_age;
                got.recorded = out_ch.recorded;
                if (owed_results.size() == 0) begin
                    report_mismatch("arrived with nothing owed", 0, got);
                end else begin
                    want = owed_results.pop_front();
                    if (got.age !== want.age)
                        report_mismatch("newest_age", want.age, got.age);
                    if (got.recorded !== want.recorded)
                        report_mismatch("recorded", want.recorded, got.recorded);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                case (in_ch.mode)
                    MODE_TICK:   n_tick++;
                    MODE_CREATE: n_create++;
                    MODE_QUERY:  n_query++;
                    default:     n_unused++;
                endcase
                // The shadow table advances on every word, typed rows included.
                want = splash_table_step(in_ch.mode, in_ch.step_time, in_ch.owner_id,
                                         in_ch.can_ripple);
                if (word_typed) begin
                    want.age      = word_exp_age;
                    want.recorded = word_exp_rec;
                end
                owed_results.push_back(want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Receiver: while stalling is enabled, ready drops at random and stays low for a random burst.
    always @(posedge i_clk) begin
        if (!sink_stall_on) begin
            out_ch.ready <= 1'b1;
        end else if (sink_hold_left > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold_left--;
        end else if ($urandom_range(0, 7) == 0) begin
            out_ch.ready   <= 1'b0;
            sink_hold_left = $urandom_range(1, 18) - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Offer one word and hold it until the block takes it. A gap, when there is one,
    // lowers valid for its whole length; otherwise valid stays high across words.
    task automatic send_word(input logic [MODE_W-1:0] mode, input logic [STEP_W-1:0] step,
                             input logic [ID_W-1:0] owner, input logic ripple,
                             input logic typed, input logic [AGE_W-1:0] exp_age,
                             input logic exp_rec);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.step_time  <= step;
        in_ch.owner_id   <= owner;
        in_ch.can_ripple <= ripple;
        word_typed       <= typed;
        word_exp_age     <= exp_age;
        word_exp_rec     <= exp_rec;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        words_sent++;
    endtask

    function automatic logic [ID_W-1:0] pick_owner();
        if ($urandom_range(0, 9) < 7) return owner_pool[$urandom_range(0, 7)];
        return ID_W'($urandom);
    endfunction

    task automatic send_random(input t_phase ph);
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] step;
        logic [ID_W-1:0]   owner;
        logic              ripple;
        int                r;
        // Fields the mode does not use still carry random bits.
        step   = STEP_W'($urandom);
        owner  = pick_owner();
        ripple = 1'($urandom);
        r      = $urandom_range(0, 99);
        if (r < 30)      mode = MODE_TICK;
        else if (r < 65) mode = MODE_CREATE;
        else if (r < 95) mode = MODE_QUERY;
        else             mode = MODE_UNUSED;
        case (ph)
            PH_FILL: begin
                mode   = MODE_CREATE;
                ripple = ($urandom_range(0, 9) != 0);
            end
            PH_SATURATE: begin
                mode = MODE_TICK;
                step = STEP_W'($urandom_range(16'hF000, 16'hFFFF));
            end
            PH_PROBE: begin
                mode = MODE_QUERY;
            end
            PH_CREEP: begin
                if (mode == MODE_TICK) step = STEP_W'($urandom_range(0, 3));
                if (mode == MODE_CREATE) ripple = ($urandom_range(0, 4) != 0);
            end
            default: begin
                if (mode == MODE_TICK && $urandom_range(0, 3) == 0)
                    step = STEP_W'($urandom_range(0, 255));
                if (mode == MODE_CREATE) ripple = ($urandom_range(0, 4) != 0);
            end
        endcase
        send_word(mode, step, owner, ripple, 1'b0, '0, 1'b0);
    endtask

    function automatic t_dir_row row(input logic [MODE_W-1:0] mode,
                                     input logic [STEP_W-1:0] step,
                                     input logic [ID_W-1:0] owner, input logic ripple,
                                     input logic typed, input logic [AGE_W-1:0] age,
                                     input logic recorded);
        t_dir_row d;
        d = '{mode, step, owner, ripple, typed, age, recorded};
        return d;
    endfunction

    initial begin
        t_dir_row d;
        int       pick;
        bit       calm;

        in_ch.valid      = 1'b0;
        in_ch.mode       = MODE_TICK;
        in_ch.step_time  = '0;
        in_ch.owner_id   = '0;
        in_ch.can_ripple = 1'b0;
        out_ch.ready     = 1'b0;
        word_typed       = 1'b0;
        word_exp_age     = '0;
        word_exp_rec     = 1'b0;
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        src_idle_on      = 1'b1;
        sink_stall_on    = 1'b1;
        sink_hold_left   = 0;
        quiet_cycles     = 0;
        rec_count        = 0;

        // Directed rows. Typed rows carry their expected result; the others rely on the
        // shadow table. Ties, the two no-op cases and duplicate owners are all here.
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'h0000, 1'b0, 1'b1, AGE_MAX, 1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'hFFFF, 16'hFFFF, 1'b1, 1'b1, AGE_MAX, 1'b0));
        dir_rows.push_back(row(MODE_TICK,   16'hFFFF, 16'h0000, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'hFFFF, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'hFFFF, 1'b1, 1'b1, '0,      1'b1));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'hFFFF, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'hFFFF, 16'h0000, 1'b1, 1'b1, '0,      1'b1));
        dir_rows.push_back(row(MODE_TICK,   16'h0005, 16'h0000, 1'b0, 1'b1, '0,      1'b0));
        // Both records now share age 5: the lower index must be the one replaced.
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'hA5A5, 1'b1, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'hFFFF, 1'b0, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'h0000, 1'b0, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'hA5A5, 1'b0, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_TICK,   16'h0001, 16'hFFFF, 1'b1, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'h5A5A, 1'b1, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'hFFFF, 16'h1111, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'h0000, 1'b1, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_TICK,   16'hFFFF, 16'h0000, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_TICK,   16'hFFFF, 16'h0000, 1'b0, 1'b1, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'h0000, 1'b0, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'h5A5A, 1'b0, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_UNUSED, 16'h0000, 16'h0000, 1'b0, 1'b1, '0,      1'b0));
        // The owner's own record ties for the largest age and is replaced: the query returns zero.
        dir_rows.push_back(row(MODE_CREATE, 16'h0000, 16'h0000, 1'b1, 1'b0, '0,      1'b0));
        dir_rows.push_back(row(MODE_QUERY,  16'h0000, 16'h0000, 1'b0, 1'b0, '0,      1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            d = dir_rows[i];
            send_word(d.mode, d.step, d.owner, d.ripple, d.typed, d.age, d.recorded);
        end

        // Random phases. Fill runs are long enough to fill the table and then keep
        // creating until every age is zero, which forces drops on the full table.
        while (words_sent < TOTAL_WORDS) begin
            calm          = (words_sent >= TOTAL_WORDS - CALM_WORDS);
            src_idle_on   = !calm && ($urandom_range(0, 2) != 0);
            sink_stall_on = !calm && ($urandom_range(0, 2) != 0);
            pick          = $urandom_range(0, 9);
            if (pick <= 4) begin
                repeat ($urandom_range(20, 60)) send_random(PH_MIX);
            end else if (pick <= 6) begin
                repeat ($urandom_range(34, 40)) send_random(PH_FILL);
                repeat (4) send_random(PH_PROBE);
            end else if (pick == 7) begin
                repeat (42) send_random(PH_SATURATE);
                repeat (6) send_random(PH_PROBE);
            end else begin
                repeat ($urandom_range(20, 40)) send_random(PH_CREEP);
            end
        end
        in_ch.valid <= 1'b0;
        sink_stall_on = 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words: %0d ticks, %0d creates, %0d queries, %0d of mode 3.",
                 words_sent, n_tick, n_create, n_query, n_unused);
        $display("Checked %0d results: %0d stored, %0d dropped, %0d saturated, %0d mismatches.",
                 results_checked, n_stored, n_dropped, n_saturated, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no word moved for %0d cycles, %0d results still owed",
                 $time, WATCHDOG_LIMIT, owed_results.size());
        $display("TB_ERROR");
        $finish;
    end

endmodule
